@@ hdl/allm_pkg.sv @@
`timescale 1ns / 1ps
// allm_pkg: shared types and codes for the array linked list manager
// request and response word structs, command and status codes, default slot count
// no dependencies
package allm_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
    } allm_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_index;
        logic [4:0] list_length;
    } allm_rsp_t;

endpackage

@@ hdl/array_linked_list_manager.sv @@
`timescale 1ns / 1ps
// array_linked_list_manager: singly linked list in a slot array with a free chain
// uses allm_pkg for the request/response words and codes
// value and link memories live inside this module
//
// One request word (insert at tail, delete first match, search) gives one
// response word with status, slot and list length. The block takes one request
// at a time: req_ready is high only between requests. A request walks the list
// one node per cycle, reading the value and link memories at the node and
// steering the next read address straight from the link read data. A walk
// visits at most SLOT_COUNT nodes. An insert on an empty list skips the walk,
// and a full list, or a delete or search on an empty list, is answered
// without a walk. The response sits in an output register, so the next
// request may be taken while it waits. No clearing pass after reset: slots
// at or above an allocation mark read their link as the next slot, which
// rebuilds the initial free chain on the fly.
module array_linked_list_manager #(
    parameter int SLOT_COUNT = allm_pkg::SLOT_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  allm_pkg::allm_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output allm_pkg::allm_rsp_t rsp
);
    import allm_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);       // slot address width
    localparam int LW = $clog2(SLOT_COUNT + 1);   // link width, holds null
    localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_STEP = IW'(SLOT_COUNT - 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FREE  = 6'b000010,
        S_WALK  = 6'b000100,
        S_WRITE = 6'b001000,
        S_LINK  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    // memories
    logic signed [31:0] value_mem [SLOT_COUNT];
    logic [LW-1:0]      link_mem  [SLOT_COUNT];
    logic signed [31:0] value_q;
    logic [LW-1:0]      link_q;

    // control state
    state_t        state_reg, state_next;
    logic [LW-1:0] list_head_reg, list_head_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] count_reg, count_next;
    logic [LW-1:0] mark_reg, mark_next;      // slots at or above never allocated
    logic          rsp_valid_reg, rsp_valid_next;

    // per-request working registers
    op_t                op_reg, op_next;
    logic signed [31:0] item_reg, item_next;
    logic [IW-1:0]      cur_reg, cur_next;
    logic [LW-1:0]      prev_reg, prev_next;
    logic [IW-1:0]      cnt_reg, cnt_next;
    logic [IW-1:0]      hit_reg, hit_next;
    logic [LW-1:0]      fix_addr_reg, fix_addr_next;  // link to patch, null means head
    logic [LW-1:0]      fix_data_reg, fix_data_next;
    logic [LW-1:0]      free_nxt_reg, free_nxt_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic [IW-1:0]      res_slot_reg, res_slot_next;
    allm_rsp_t          rsp_reg, rsp_next;

    // memory port controls
    logic [IW-1:0]      rd_addr;
    logic               val_we;
    logic               lnk_we;
    logic [IW-1:0]      lnk_waddr;
    logic [LW-1:0]      lnk_wdata;

    logic               free_fresh;
    logic [LW-1:0]      free_link;
    logic               nxt_null;
    logic               walk_end;
    logic               val_match;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // link of the free head: untouched slots still chain to the next slot
    assign free_fresh = (free_head_reg >= mark_reg);
    assign free_link  = free_fresh ? (free_head_reg + LW'(1)) : link_q;

    assign nxt_null  = !(link_q < NIL);
    assign walk_end  = nxt_null || (cnt_reg == LAST_STEP);
    assign val_match = (value_q == item_reg);

    always_comb
    begin
        state_next      = state_reg;
        list_head_next  = list_head_reg;
        free_head_next  = free_head_reg;
        count_next      = count_reg;
        mark_next       = mark_reg;
        rsp_valid_next  = rsp_valid_reg;
        op_next         = op_reg;
        item_next       = item_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        fix_addr_next   = fix_addr_reg;
        fix_data_next   = fix_data_reg;
        free_nxt_next   = free_nxt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        rsp_next        = rsp_reg;
        rd_addr         = list_head_reg[IW-1:0];
        val_we          = 1'b0;
        lnk_we          = 1'b0;
        lnk_waddr       = fix_addr_reg[IW-1:0];
        lnk_wdata       = fix_data_reg;

        // response word leaves
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.cmd == CMD_INSERT)
                begin
                    rd_addr = free_head_reg[IW-1:0];
                end
                if (req_valid)
                begin
                    item_next       = req.item_value;
                    prev_next       = NIL;
                    cnt_next        = '0;
                    cur_next        = list_head_reg[IW-1:0];
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                    if (req.cmd == CMD_INSERT)
                    begin
                        op_next = OP_INSERT;
                        if (!(free_head_reg < NIL))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else
                    begin
                        op_next = (req.cmd == CMD_DELETE) ? OP_DELETE : OP_SEARCH;
                        if (!(list_head_reg < NIL))
                        begin
                            res_status_next = ST_MISSING;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                end
            end

            S_FREE:
            begin
                // link of the slot about to be taken; walk unless the list is empty
                free_nxt_next = free_link;
                fix_data_next = free_head_reg;
                if (!(list_head_reg < NIL))
                begin
                    fix_addr_next = NIL;
                    state_next    = S_WRITE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end

            S_WALK:
            begin
                // read data belongs to cur; next address comes from its link
                rd_addr  = link_q[IW-1:0];
                cur_next = link_q[IW-1:0];
                prev_next = LW'(cur_reg);
                cnt_next = cnt_reg + IW'(1);
                if (op_reg != OP_INSERT && val_match)
                begin
                    hit_next      = cur_reg;
                    res_slot_next = cur_reg;
                    if (op_reg == OP_DELETE)
                    begin
                        fix_addr_next = prev_reg;
                        fix_data_next = link_q;
                        state_next    = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (walk_end)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        fix_addr_next = LW'(cur_reg);
                        state_next    = S_WRITE;
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                        state_next      = S_DONE;
                    end
                end
            end

            S_WRITE:
            begin
                lnk_we = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    // new tail node: value, null link, pop free chain
                    val_we         = 1'b1;
                    lnk_waddr      = free_head_reg[IW-1:0];
                    lnk_wdata      = NIL;
                    free_head_next = free_nxt_reg;
                    count_next     = count_reg + LW'(1);
                    res_slot_next  = free_head_reg[IW-1:0];
                    if (free_head_reg == mark_reg)
                    begin
                        mark_next = mark_reg + LW'(1);
                    end
                end
                else
                begin
                    // unlinked node goes on the free chain head
                    lnk_waddr      = hit_reg;
                    lnk_wdata      = free_head_reg;
                    free_head_next = LW'(hit_reg);
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - LW'(1);
                    end
                end
                if (!(fix_addr_reg < NIL))
                begin
                    list_head_next = fix_data_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                lnk_we     = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = res_status_reg;
                    rsp_next.slot_index  = 4'(res_slot_reg);
                    rsp_next.list_length = 5'(count_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            count_reg     <= '0;
            mark_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        item_reg       <= item_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        cnt_reg        <= cnt_next;
        hit_reg        <= hit_next;
        fix_addr_reg   <= fix_addr_next;
        fix_data_reg   <= fix_data_next;
        free_nxt_reg   <= free_nxt_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rsp_reg        <= rsp_next;
    end

    // value and link memories, registered read
    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[free_head_reg[IW-1:0]] <= item_reg;
        end
        if (lnk_we)
        begin
            link_mem[lnk_waddr] <= lnk_wdata;
        end
        value_q <= value_mem[rd_addr];
        link_q  <= link_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // an empty free chain means the list holds every slot
    a_free_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == NIL) |-> (count_reg == NIL))
        else $error("free chain empty while list not full");

    a_list_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (list_head_reg == NIL) |-> (count_reg == '0))
        else $error("list head null with nonzero length");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= NIL) && (mark_reg <= NIL))
        else $error("length or allocation mark beyond slot count");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside the done step");
`endif

endmodule
